>>> sv/dcfs_pkg.sv
// Shared types, constants and helpers of the drive command frame sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dcfs_pkg;

   // Frame layout
   localparam logic [7:0] FrameStart   = 8'hEB;
   localparam logic [7:0] IdSteer      = 8'h01;
   localparam logic [7:0] IdSpeed      = 8'h02;
   localparam logic [7:0] IdNoCmd      = 8'h04;
   localparam logic [7:0] IdMaxSpeed   = 8'h08;
   localparam logic [7:0] Setup1Button = 8'h40;
   localparam int         FrameBytes   = 6;
   localparam int         ByteIdxW     = $clog2(FrameBytes);

   // Configuration register reset values
   localparam logic [7:0]  MaxSpeedReset = 8'd100;
   localparam logic [7:0]  Setup1Reset   = 8'd128;
   localparam logic [7:0]  Setup2Reset   = 8'd176;
   localparam logic [14:0] MagReset      = 15'd1000;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 15;

   // Frame queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MAX_SPEED = 2'd0,
      CSR_SETUP1    = 2'd1,
      CSR_SETUP2    = 2'd2,
      CSR_MAGNITUDE = 2'd3
   } csr_idx_type;

   // One frame to send: message ID, 16-bit data and whether it closes the tick
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] value;
      logic        last;
   } frame_type;

   // Map a demand to +magnitude, -magnitude or zero by its sign
   function automatic logic [15:0] demand_value(input logic signed [7:0] demand,
                                                input logic [14:0] magnitude);
      logic [15:0] mag16;
      mag16 = {1'b0, magnitude};
      if (demand == 8'sd0) begin
         return 16'd0;
      end else if (demand[7]) begin
         return 16'd0 - mag16;
      end else begin
         return mag16;
      end
   endfunction

endpackage

`default_nettype wire

>>> sv/dcfs_ifs.sv
// Handshake channel interfaces for demand ticks and transmit bytes.
`timescale 1ns / 1ps
`default_nettype none

interface dcfs_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] speed_demand;
   logic signed [7:0] direction_demand;

   modport source (output valid, output speed_demand, output direction_demand,
                   input ready);
   modport sink   (input valid, input speed_demand, input direction_demand,
                   output ready);
endinterface

interface dcfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic       last_of_run;

   modport source (output valid, output tx_byte, output frame_end, output last_of_run,
                   input ready);
   modport sink   (input valid, input tx_byte, input frame_end, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

>>> sv/drive_command_frame_sequencer_unit.sv
// Top level of the drive command frame sequencer.
//
//   Channel  Direction  Payload                                Moves per transfer
//   req_bus  in         speed_demand, direction_demand (s8)    one demand tick
//   rsp_bus  out        tx_byte, frame_end, last_of_run        one serial byte
//   csr_*    in         csr_index (2b), csr_data (15b)         one register write
//
// A tick yields one six-byte frame during start-up (six ticks) and twelve bytes
// afterwards; the serialiser sends one byte per cycle while rsp is ready and the
// queue holds frames.
// The front end takes a tick and pushes its first frame together; a running tick
// holds its speed frame in a register and pushes it once the queue has room, taking
// no new tick meanwhile. It keeps taking ticks while the four-frame queue has room.
// Reset is synchronous, active high; it restores the register defaults and
// returns the sequence to the max speed frame. rsp stalls back-pressure the queue.
`timescale 1ns / 1ps
`default_nettype none

module drive_command_frame_sequencer_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_en,
   input  wire  [dcfs_pkg::CsrIdxW-1:0]   csr_index,
   input  wire  [dcfs_pkg::CsrDataW-1:0]  csr_data,
   dcfs_req_if.sink                       req_bus,
   dcfs_rsp_if.source                     rsp_bus
);

   // Frame descriptors from the front end into the queue
   logic                 push_valid;
   logic                 push_ready;
   dcfs_pkg::frame_type  push_frame;
   // Frame descriptors from the queue into the serialiser
   logic                 pop_valid;
   logic                 pop_ready;
   dcfs_pkg::frame_type  pop_frame;

   // Classify each tick into frames; hold the speed frame back one push
   dcfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_bus      (req_bus),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_frame   (push_frame)
   );

   // Buffer frames so the front end can run ahead of the serial stream
   dcfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   // Add the checksum and advance one byte per transfer
   dcfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_frame (pop_frame),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> sv/dcfs_front.sv
// Front end: configuration registers, start-up phase and frame classification.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write_en,
   input  wire  [dcfs_pkg::CsrIdxW-1:0]     csr_index,
   input  wire  [dcfs_pkg::CsrDataW-1:0]    csr_data,
   dcfs_req_if.sink                         req_bus,
   output logic                             push_valid,
   input  wire                              push_ready,
   output dcfs_pkg::frame_type              push_frame
);

   typedef enum logic [2:0] {
      PH_MAX_SPEED = 3'd0,
      PH_NOCMD_A   = 3'd1,
      PH_SETUP1    = 3'd2,
      PH_NOCMD_B   = 3'd3,
      PH_SETUP2    = 3'd4,
      PH_NOCMD_C   = 3'd5,
      PH_RUN       = 3'd6
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 pend_valid_ff, pend_valid_in;
   dcfs_pkg::frame_type  pend_ff, pend_in;
   logic [7:0]           max_speed_ff;
   logic [7:0]           setup1_ff;
   logic [7:0]           setup2_ff;
   logic [14:0]          magnitude_ff;

   logic                 accept;
   logic                 running;
   dcfs_pkg::frame_type  first_frame;

   assign req_bus.ready = !pend_valid_ff && push_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Classify the tick: one start-up frame, or steering now and speed held back
   always_comb begin
      running  = 1'b0;
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_MAX_SPEED: begin
            first_frame = '{id: dcfs_pkg::IdMaxSpeed, value: {max_speed_ff, 8'h00},
                            last: 1'b1};
            phase_in    = PH_NOCMD_A;
         end
         PH_SETUP1: begin
            first_frame = '{id: dcfs_pkg::IdNoCmd,
                            value: {dcfs_pkg::Setup1Button, setup1_ff}, last: 1'b1};
            phase_in    = PH_NOCMD_B;
         end
         PH_SETUP2: begin
            first_frame = '{id: dcfs_pkg::IdNoCmd, value: {8'h00, setup2_ff}, last: 1'b1};
            phase_in    = PH_NOCMD_C;
         end
         PH_NOCMD_A, PH_NOCMD_B, PH_NOCMD_C: begin
            first_frame = '{id: dcfs_pkg::IdNoCmd, value: 16'h0000, last: 1'b1};
            phase_in    = phase_type'(phase_ff + 3'd1);
         end
         default: begin
            running     = 1'b1;
            first_frame = '{id: dcfs_pkg::IdSteer,
                            value: dcfs_pkg::demand_value(req_bus.direction_demand,
                                                          magnitude_ff),
                            last: 1'b0};
            phase_in    = PH_RUN;
         end
      endcase
   end

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (accept && running) begin
         pend_valid_in = 1'b1;
         pend_in       = '{id: dcfs_pkg::IdSpeed,
                           value: dcfs_pkg::demand_value(req_bus.speed_demand, magnitude_ff),
                           last: 1'b1};
      end else if (pend_valid_ff && push_ready) begin
         pend_valid_in = 1'b0;
      end
   end

   assign push_valid = pend_valid_ff || accept;
   assign push_frame = pend_valid_ff ? pend_ff : first_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAX_SPEED;
         pend_valid_ff <= 1'b0;
         max_speed_ff  <= dcfs_pkg::MaxSpeedReset;
         setup1_ff     <= dcfs_pkg::Setup1Reset;
         setup2_ff     <= dcfs_pkg::Setup2Reset;
         magnitude_ff  <= dcfs_pkg::MagReset;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         pend_valid_ff <= pend_valid_in;
         if (csr_write_en) begin
            unique case (dcfs_pkg::csr_idx_type'(csr_index))
               dcfs_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_data[7:0];
               dcfs_pkg::CSR_SETUP1:    setup1_ff    <= csr_data[7:0];
               dcfs_pkg::CSR_SETUP2:    setup2_ff    <= csr_data[7:0];
               dcfs_pkg::CSR_MAGNITUDE: magnitude_ff <= csr_data[14:0];
            endcase
         end
      end
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

>>> sv/dcfs_queue.sv
// Short frame queue decoupling the front end from the byte serialiser.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  dcfs_pkg::frame_type  push_frame,
   output logic                 pop_valid,
   input  wire                  pop_ready,
   output dcfs_pkg::frame_type  pop_frame
);

   dcfs_pkg::frame_type             mem [dcfs_pkg::QDepth];
   logic [dcfs_pkg::QPtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dcfs_pkg::QPtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dcfs_pkg::QCntW-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != dcfs_pkg::QCntW'(dcfs_pkg::QDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_frame  = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

`default_nettype wire

>>> sv/dcfs_back.sv
// Back end: checksum and byte serialiser with a registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  pop_valid,
   output logic                 pop_ready,
   input  dcfs_pkg::frame_type  pop_frame,
   dcfs_rsp_if.source           rsp_bus
);

   dcfs_pkg::frame_type              frame_ff;
   logic [15:0]                      check_ff, check_in;
   logic                             cur_valid_ff, cur_valid_in;
   logic [dcfs_pkg::ByteIdxW-1:0]    idx_ff, idx_in;
   logic                             out_valid_ff, out_valid_in;
   logic [7:0]                       byte_ff, byte_in;
   logic                             end_ff, end_in;
   logic                             last_ff, last_in;

   logic                             advance;
   logic                             final_byte;
   logic [15:0]                      sum;

   assign final_byte = idx_ff == dcfs_pkg::ByteIdxW'(dcfs_pkg::FrameBytes - 1);
   assign advance    = cur_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign pop_ready  = !cur_valid_ff || (advance && final_byte);

   assign sum = 16'(dcfs_pkg::FrameStart) + 16'(pop_frame.id)
              + 16'(pop_frame.value[15:8]) + 16'(pop_frame.value[7:0]);
   assign check_in = 16'd0 - sum;

   always_comb begin
      unique case (idx_ff)
         3'd0:    byte_in = dcfs_pkg::FrameStart;
         3'd1:    byte_in = frame_ff.id;
         3'd2:    byte_in = frame_ff.value[15:8];
         3'd3:    byte_in = frame_ff.value[7:0];
         3'd4:    byte_in = check_ff[15:8];
         default: byte_in = check_ff[7:0];
      endcase
      end_in  = final_byte;
      last_in = final_byte && frame_ff.last;
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop_valid && pop_ready) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (advance) begin
         cur_valid_in = !final_byte;
         idx_in       = idx_ff + 1'b1;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      if (pop_valid && pop_ready) begin
         frame_ff <= pop_frame;
         check_ff <= check_in;
      end
      if (advance) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.tx_byte     = byte_ff;
   assign rsp_bus.frame_end   = end_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule

`default_nettype wire

>>> sv/dcfs_checker.sv
// Port-level checks on the byte stream of the frame sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_tx_byte,
   input wire       rsp_frame_end,
   input wire       rsp_last_of_run
);

   logic [dcfs_pkg::ByteIdxW-1:0] pos_ff, pos_in;
   logic                          xfer;

   assign xfer = rsp_valid && rsp_ready;

   always_comb begin
      pos_in = pos_ff;
      if (xfer) begin
         pos_in = rsp_frame_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Frame end marks exactly the sixth byte of each frame
   assert property (@(posedge clock) disable iff (reset)
      xfer |-> (rsp_frame_end == (pos_ff == dcfs_pkg::ByteIdxW'(dcfs_pkg::FrameBytes - 1))))
      else $error("frame_end not on sixth byte");

   // Every frame opens with the start byte
   assert property (@(posedge clock) disable iff (reset)
      (xfer && pos_ff == '0) |-> (rsp_tx_byte == dcfs_pkg::FrameStart))
      else $error("frame does not open with start byte");

   // A tick always closes on a frame boundary
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> rsp_frame_end)
      else $error("last_of_run away from frame end");

   // A stalled byte stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

endmodule

bind drive_command_frame_sequencer_unit dcfs_checker u_dcfs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_tx_byte     (rsp_bus.tx_byte),
   .rsp_frame_end   (rsp_bus.frame_end),
   .rsp_last_of_run (rsp_bus.last_of_run)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the drive command frame sequencer top level.
`timescale 1ns / 1ps

module tb;

   localparam int       CyclesLimit = 300000;
   localparam int       SettleCycles = 8;
   localparam int       RandomRounds = 6;
   localparam int       TicksPerRound = 31;

   // Start-up steps; anything from StepRun up sends steering and speed frames
   localparam logic [2:0] StepMaxSpeed = 3'd0;
   localparam logic [2:0] StepSetup1   = 3'd2;
   localparam logic [2:0] StepSetup2   = 3'd4;
   localparam logic [2:0] StepRun      = 3'd6;

   // One serial byte as the block should hand it over
   typedef struct {
      logic [7:0] data;
      logic       frame_end;
      logic       last;
   } tx_beat_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   dcfs_pkg::csr_idx_type           csr_index;
   logic [dcfs_pkg::CsrDataW-1:0]   csr_data;

   dcfs_req_if req_bus ();
   dcfs_rsp_if rsp_bus ();

   drive_command_frame_sequencer_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus)
   );

   // Shadow copy of the block's registers and sequence position
   logic [7:0]  max_speed_cfg;
   logic [7:0]  setup1_cfg;
   logic [7:0]  setup2_cfg;
   logic [14:0] magnitude_cfg;
   logic [2:0]  startup_step;

   tx_beat_type pending_tx_bytes[$];
   int          error_count;
   int          cycle_count;
   int          burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Turn a demand into the signed 16-bit drive word by its sign alone
   function automatic logic [15:0] drive_word(input logic signed [7:0] demand);
      if (demand == 8'sd0) begin
         return 16'd0;
      end else if (demand < 0) begin
         return 16'd0 - {1'b0, magnitude_cfg};
      end else begin
         return {1'b0, magnitude_cfg};
      end
   endfunction

   // Build one six-byte frame and queue its bytes
   function automatic void queue_frame(input logic [7:0] id, input logic [15:0] word,
                                       input logic closes_tick);
      logic [7:0]  frame[6];
      logic [15:0] check;
      tx_beat_type beat;
      frame[0] = dcfs_pkg::FrameStart;
      frame[1] = id;
      frame[2] = word[15:8];
      frame[3] = word[7:0];
      check = 16'd0 - (16'(frame[0]) + 16'(frame[1]) + 16'(frame[2]) + 16'(frame[3]));
      frame[4] = check[15:8];
      frame[5] = check[7:0];
      for (int i = 0; i < 6; i++) begin
         beat.data      = frame[i];
         beat.frame_end = (i == 5);
         beat.last      = closes_tick && (i == 5);
         pending_tx_bytes.push_back(beat);
      end
   endfunction

   // Work out every byte one accepted tick should produce, then advance the sequence
   function automatic void predict_tick_bytes(input logic signed [7:0] speed,
                                              input logic signed [7:0] direction);
      if (startup_step == StepMaxSpeed) begin
         queue_frame(dcfs_pkg::IdMaxSpeed, {max_speed_cfg, 8'h00}, 1'b1);
      end else if (startup_step == StepSetup1) begin
         queue_frame(dcfs_pkg::IdNoCmd, {dcfs_pkg::Setup1Button, setup1_cfg}, 1'b1);
      end else if (startup_step == StepSetup2) begin
         queue_frame(dcfs_pkg::IdNoCmd, {8'h00, setup2_cfg}, 1'b1);
      end else if (startup_step < StepRun) begin
         queue_frame(dcfs_pkg::IdNoCmd, 16'h0000, 1'b1);
      end else begin
         // steering goes first, the speed frame closes the tick
         queue_frame(dcfs_pkg::IdSteer, drive_word(direction), 1'b0);
         queue_frame(dcfs_pkg::IdSpeed, drive_word(speed), 1'b1);
      end
      startup_step = (startup_step < StepRun) ? startup_step + 3'd1 : StepRun;
   endfunction

   // Offer one tick and hold it until the transfer happens. Valid stays high on
   // return so that a following tick in the same burst keeps the channel busy.
   task automatic send_tick(input logic signed [7:0] speed,
                            input logic signed [7:0] direction);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_bus.valid            <= 1'b1;
      req_bus.speed_demand     <= speed;
      req_bus.direction_demand <= direction;
      do @(posedge clock); while (!req_bus.ready);
      predict_tick_bytes(speed, direction);
   endtask

   // Drop valid, wait for every predicted byte, then let the pipeline settle
   task automatic drain_tx;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_tx_bytes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one register; the block must be idle
   task automatic write_register(input dcfs_pkg::csr_idx_type idx,
                                 input logic [dcfs_pkg::CsrDataW-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      case (idx)
         dcfs_pkg::CSR_MAX_SPEED: max_speed_cfg = value[7:0];
         dcfs_pkg::CSR_SETUP1:    setup1_cfg    = value[7:0];
         dcfs_pkg::CSR_SETUP2:    setup2_cfg    = value[7:0];
         dcfs_pkg::CSR_MAGNITUDE: magnitude_cfg = value[14:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [7:0] random_demand;
      case ($urandom_range(0, 9))
         0, 1:    return 8'sd0;
         2:       return 8'sd100;
         3:       return -8'sd100;
         4:       return ($urandom_range(0, 1) != 0) ? 8'sd1 : -8'sd1;
         default: return 8'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   // Start-up: six ticks, one frame each, from the reset register values.
   // Demands are ignored here, so feed extremes and watch them vanish.
   task automatic test_startup_sequence;
      send_tick(8'sd100, -8'sd100);
      send_tick(-8'sd100, 8'sd100);
      send_tick(8'sd0, 8'sd0);
      send_tick(-8'sd1, -8'sd1);
      send_tick(8'sd1, 8'sd1);
      send_tick(8'sd100, 8'sd0);
      drain_tx;
   endtask

   // Running frames with the reset magnitude: seven of the nine pairings of signs
   task automatic test_demand_signs;
      send_tick(8'sd100, 8'sd100);
      send_tick(-8'sd100, -8'sd100);
      send_tick(8'sd0, 8'sd0);
      send_tick(8'sd1, -8'sd1);
      send_tick(-8'sd1, 8'sd1);
      send_tick(8'sd100, 8'sd0);
      send_tick(8'sd0, -8'sd100);
      drain_tx;
   endtask

   // Magnitude at zero, full scale and one; start-up registers written at their extremes too
   task automatic test_register_extremes;
      logic [14:0] mags[3];
      mags = '{15'd0, 15'h7FFF, 15'd1};
      write_register(dcfs_pkg::CSR_MAX_SPEED, 15'h00FF);
      write_register(dcfs_pkg::CSR_SETUP1, 15'h0000);
      write_register(dcfs_pkg::CSR_SETUP2, 15'h7FFF);
      foreach (mags[i]) begin
         write_register(dcfs_pkg::CSR_MAGNITUDE, mags[i]);
         send_tick(-8'sd100, 8'sd100);
         send_tick(8'sd0, -8'sd1);
         send_tick(8'sd1, 8'sd0);
         drain_tx;
      end
      write_register(dcfs_pkg::CSR_MAX_SPEED, 15'h0000);
      write_register(dcfs_pkg::CSR_SETUP1, 15'h00FF);
   endtask

   // Rounds of random ticks, each under a fresh register setting
   task automatic test_random_ticks;
      logic [14:0] mag;
      for (int round = 0; round < RandomRounds; round++) begin
         case ($urandom_range(0, 4))
            0:       mag = 15'd0;
            1:       mag = 15'h7FFF;
            default: mag = 15'($urandom_range(0, 32767));
         endcase
         write_register(dcfs_pkg::CSR_MAX_SPEED, 15'($urandom_range(0, 32767)));
         write_register(dcfs_pkg::CSR_SETUP1, 15'($urandom_range(0, 32767)));
         write_register(dcfs_pkg::CSR_SETUP2, 15'($urandom_range(0, 32767)));
         write_register(dcfs_pkg::CSR_MAGNITUDE, mag);
         for (int n = 0; n < TicksPerRound; n++) begin
            send_tick(random_demand(), random_demand());
         end
         drain_tx;
      end
   endtask

   // Stimulus: reset once, then run the tests in turn and give the verdict
   initial begin
      reset                    <= 1'b1;
      csr_write_en             <= 1'b0;
      csr_index                <= dcfs_pkg::CSR_MAX_SPEED;
      csr_data                 <= '0;
      req_bus.valid            <= 1'b0;
      req_bus.speed_demand     <= 8'sd0;
      req_bus.direction_demand <= 8'sd0;
      max_speed_cfg = dcfs_pkg::MaxSpeedReset;
      setup1_cfg    = dcfs_pkg::Setup1Reset;
      setup2_cfg    = dcfs_pkg::Setup2Reset;
      magnitude_cfg = dcfs_pkg::MagReset;
      startup_step  = StepMaxSpeed;
      burst_left    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_startup_sequence;
      test_demand_signs;
      test_register_extremes;
      test_random_ticks;

      if (error_count == 0) begin
         $display("drive_command_frame_sequencer_unit: match");
      end else begin
         $display("drive_command_frame_sequencer_unit: mismatch");
      end
      $finish;
   end

   // Byte checker, receiver stall pattern and watchdog. Compare each transfer
   // with the oldest prediction, then pick the ready level for the next edge.
   initial begin
      tx_beat_type want;
      int          rx_mode;
      int          hold_count;
      logic        hold_level;
      error_count = 0;
      cycle_count = 0;
      rx_mode     = 0;
      hold_count  = 0;
      hold_level  = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CyclesLimit) begin
            $display("%0t: timed out with %0d bytes outstanding", $time,
                     pending_tx_bytes.size());
            $display("drive_command_frame_sequencer_unit: mismatch");
            $finish;
         end
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_tx_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected byte: expected none, actual %02h", $time,
                        rsp_bus.tx_byte);
            end else begin
               want = pending_tx_bytes.pop_front();
               if (rsp_bus.tx_byte !== want.data) begin
                  error_count++;
                  $display("%0t: tx_byte wrong: expected %02h, actual %02h", $time,
                           want.data, rsp_bus.tx_byte);
               end
               if (rsp_bus.frame_end !== want.frame_end) begin
                  error_count++;
                  $display("%0t: frame_end wrong: expected %b, actual %b", $time,
                           want.frame_end, rsp_bus.frame_end);
               end
               if (rsp_bus.last_of_run !== want.last) begin
                  error_count++;
                  $display("%0t: last_of_run wrong: expected %b, actual %b", $time,
                           want.last, rsp_bus.last_of_run);
               end
            end
         end
         // change stall behaviour every so often so that gaps land on any byte
         if (cycle_count % 97 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: begin
               if (hold_count == 0) begin
                  hold_level = ~hold_level;
                  hold_count = $urandom_range(1, 12);
               end
               hold_count--;
               rsp_bus.ready <= hold_level;
            end
            default: rsp_bus.ready <= cycle_count[0];
         endcase
      end
   end

endmodule
